// ----- hw/rtl/lrle_pkg.sv -----
// Shared types and constants for the run-length pattern body expander.
`default_nettype none
package lrle_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] ROW_WIDTH_RESET = 16'd1;
  localparam logic [FIELD_W-1:0] SKIP_RESET      = 16'd100;
  localparam logic [FIELD_W-1:0] FIELD_MAX       = 16'hFFFF;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH  = 2'd0,
    REG_SKIP_FROM  = 2'd1,
    REG_SKIP_UNTIL = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               pixel_value;
    logic [FIELD_W-1:0] run_length;
    logic               ends_row;
    logic [FIELD_W-1:0] row_repeat;
    logic               pattern_done;
    logic               last;
  } lrle_res_t;

  // Up to two results pushed into the output queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    lrle_res_t  r0;
    lrle_res_t  r1;
  } lrle_push_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lrle_ifs.sv -----
// Valid/ready channel interfaces for body bytes and result items.
`default_nettype none
interface lrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;

  modport source (output valid, output body_byte, input ready);
  modport sink   (input valid, input body_byte, output ready);
endinterface

interface lrle_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_value;
  logic [15:0] run_length;
  logic        ends_row;
  logic [15:0] row_repeat;
  logic        pattern_done;
  logic        last;

  modport source (output valid, output pixel_value, output run_length, output ends_row,
                  output row_repeat, output pattern_done, output last, input ready);
  modport sink   (input valid, input pixel_value, input run_length, input ends_row,
                  input row_repeat, input pattern_done, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lrle_decode.sv -----
// Input register, token state and run computation for one body byte.
`default_nettype none
module lrle_decode #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lrle_in_if.sink                            in_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lrle_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [lrle_pkg::FIELD_W-1:0]   cfg_data,
  input  wire logic [1:0]                    q_free,
  output lrle_pkg::lrle_push_t               push
);
  import lrle_pkg::*;

  localparam int unsigned SW = ((COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W) + 1;
  localparam int unsigned VW = COUNT_BITS + 4;

  logic                  in_vld_r;
  logic [7:0]            byte_r;
  logic [FIELD_W-1:0]    row_width_r, skip_from_r, skip_until_r;
  logic [FIELD_W-1:0]    column_r, column_nxt;
  logic [COUNT_BITS-1:0] acc_r, acc_nxt;
  logic                  have_r, have_nxt;
  logic                  fin_r, fin_nxt;

  logic                  fire;
  logic [COUNT_BITS-1:0] cnt;
  logic [VW-1:0]         dig_v;
  logic [SW-1:0]         end_w;
  logic [FIELD_W-1:0]    end16;
  logic [SW-1:0]         cm1_w;
  logic [FIELD_W-1:0]    rep2;
  logic                  is_digit, is_run, is_end, done;
  lrle_push_t            push_c;

  // Pixels in [a, b) outside the skip window
  function automatic logic [FIELD_W-1:0] clip_len(
    input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
    input logic [FIELD_W-1:0] sf, input logic [FIELD_W-1:0] su);
    logic [FIELD_W-1:0] lo, hi, ov;
    begin
      ov = '0;
      lo = (a > sf) ? a : sf;
      hi = (b < su) ? b : su;
      if (su > sf && hi > lo) ov = hi - lo;
      if (b <= a) return '0;
      return (b - a) - ov;
    end
  endfunction

  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign is_run   = (byte_r == CH_B) || (byte_r == CH_O);
  assign is_end   = (byte_r == CH_DOLLAR) || (byte_r == CH_BANG);
  assign done     = (byte_r == CH_BANG);
  assign cnt      = have_r ? acc_r : COUNT_BITS'(1);

  // acc * 10 + digit, saturate at the counter width
  assign dig_v = (VW'(acc_r) << 3) + (VW'(acc_r) << 1) + VW'(byte_r - CH_ZERO);

  assign end_w = SW'(column_r) + SW'(cnt);
  assign end16 = (end_w > SW'(FIELD_MAX)) ? FIELD_MAX : end_w[FIELD_W-1:0];
  assign cm1_w = SW'(cnt) - SW'(1);
  assign rep2  = (cm1_w > SW'(FIELD_MAX)) ? FIELD_MAX : cm1_w[FIELD_W-1:0];

  always_comb begin
    push_c     = '0;
    column_nxt = column_r;
    acc_nxt    = acc_r;
    have_nxt   = have_r;
    fin_nxt    = fin_r;
    priority if (fin_r) begin
      // drop everything after the end of the pattern
    end else if (is_digit) begin
      acc_nxt  = (dig_v[VW-1:COUNT_BITS] != '0) ? '1 : dig_v[COUNT_BITS-1:0];
      have_nxt = 1'b1;
    end else begin
      acc_nxt  = '0;
      have_nxt = 1'b0;
      if (is_run) begin
        push_c.n                 = 2'd1;
        push_c.r0.pixel_value    = (byte_r == CH_B);
        push_c.r0.run_length     = clip_len(column_r, end16, skip_from_r, skip_until_r);
        push_c.r0.row_repeat     = FIELD_W'(1);
        push_c.r0.last           = 1'b1;
        column_nxt               = end16;
      end else if (is_end) begin
        fin_nxt = done;
        if (cnt == '0) begin
          if (done) begin
            push_c.n                 = 2'd1;
            push_c.r0.pixel_value    = 1'b1;
            push_c.r0.pattern_done   = 1'b1;
            push_c.r0.last           = 1'b1;
          end
        end else begin
          push_c.n                 = (cnt == COUNT_BITS'(1)) ? 2'd1 : 2'd2;
          push_c.r0.pixel_value    = 1'b1;
          push_c.r0.run_length     = clip_len(column_r, row_width_r, skip_from_r,
                                              skip_until_r);
          push_c.r0.ends_row       = 1'b1;
          push_c.r0.row_repeat     = FIELD_W'(1);
          push_c.r0.pattern_done   = done;
          push_c.r0.last           = (cnt == COUNT_BITS'(1));
          push_c.r1.pixel_value    = 1'b1;
          push_c.r1.run_length     = clip_len('0, row_width_r, skip_from_r, skip_until_r);
          push_c.r1.ends_row       = 1'b1;
          push_c.r1.row_repeat     = rep2;
          push_c.r1.pattern_done   = done;
          push_c.r1.last           = 1'b1;
          column_nxt               = '0;
        end
      end
    end
  end

  assign fire         = in_vld_r && (push_c.n <= q_free);
  assign in_ch.ready  = !in_vld_r || fire;
  assign push.n       = fire ? push_c.n : 2'd0;
  assign push.r0      = push_c.r0;
  assign push.r1      = push_c.r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.body_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      acc_r    <= '0;
      have_r   <= 1'b0;
      fin_r    <= 1'b0;
    end else if (fire) begin
      column_r <= column_nxt;
      acc_r    <= acc_nxt;
      have_r   <= have_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= ROW_WIDTH_RESET;
      skip_from_r  <= SKIP_RESET;
      skip_until_r <= SKIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ROW_WIDTH:  row_width_r  <= cfg_data;
        REG_SKIP_FROM:  skip_from_r  <= cfg_data;
        REG_SKIP_UNTIL: skip_until_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lrle_outq.sv -----
// Two-entry result queue that drives the output channel.
`default_nettype none
module lrle_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lrle_pkg::lrle_push_t push,
  output logic [1:0]         q_free,
  lrle_out_if.source         out_ch
);
  import lrle_pkg::*;

  lrle_res_t  q_r [2];
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic       wr;
  lrle_res_t  head;

  assign pop     = (cnt_r != 2'd0) && out_ch.ready;
  assign q_free  = 2'd2 - cnt_r + {1'b0, pop};
  assign wr      = rd_r ^ cnt_r[0];
  assign cnt_nxt = cnt_r - {1'b0, pop} + push.n;
  assign rd_nxt  = rd_r ^ pop;
  assign head    = q_r[rd_r];

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.pixel_value  = head.pixel_value;
  assign out_ch.run_length   = head.run_length;
  assign out_ch.ends_row     = head.ends_row;
  assign out_ch.row_repeat   = head.row_repeat;
  assign out_ch.pattern_done = head.pattern_done;
  assign out_ch.last         = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // A two-result push only happens into a queue that is empty once this cycle's pop is taken
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[~wr] <= push.r1;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/life_rle_run_expander_unit.sv -----
// Top level of the run-length pattern body expander.
// A byte is registered when accepted; its results enter the output queue once the queue
//   has room for them, and are presented from the queue.
// Throughput: one byte per cycle while the output queue has room for its results; a row
//   end with count above 1 gives two results, which leave one at a time through the single-result output port.
// Reset (synchronous, rst_n low) clears column, count and end flag, empties the
//   queue and loads row_width 1, skip_from 100, skip_until 100.
`default_nettype none
module life_rle_run_expander_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lrle_in_if.sink                            in_ch,
  lrle_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lrle_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [lrle_pkg::FIELD_W-1:0]   cfg_data
);
  import lrle_pkg::*;

  lrle_push_t push;
  logic [1:0] q_free;

  lrle_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_free   (q_free),
    .push     (push)
  );

  lrle_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_free (q_free),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for life_rle_run_expander_unit: body bytes in, predicted run items checked.
module tb;
  import lrle_pkg::*;

  localparam int unsigned COUNT_BITS    = 16;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned LIMIT_CYCLES  = 600000;
  localparam int unsigned PHASE_ITEMS   = 225;
  localparam int unsigned MAX_PRINTS    = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_idx;
  logic [FIELD_W-1:0] cfg_data;

  lrle_in_if  in_ch ();
  lrle_out_if out_ch ();

  life_rle_run_expander_unit #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Expander state as the block should hold it
  logic [FIELD_W-1:0]    row_width_cfg, skip_from_cfg, skip_until_cfg;
  logic [FIELD_W-1:0]    col_pos;
  logic [COUNT_BITS-1:0] count_acc;
  logic                  digits_seen;
  logic                  body_done;

  lrle_res_t runs_due[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic rx_hold = 1'b0;
  event hold_go;

  function automatic void reset_model();
    row_width_cfg  = ROW_WIDTH_RESET;
    skip_from_cfg  = SKIP_RESET;
    skip_until_cfg = SKIP_RESET;
    col_pos        = '0;
    count_acc      = '0;
    digits_seen    = 1'b0;
    body_done      = 1'b0;
  endfunction

  // Cells in [a, b) that survive the skip window
  function automatic logic [FIELD_W-1:0] visible_cells(longint unsigned a, longint unsigned b);
    longint unsigned lo, hi, cut;
    cut = 0;
    if (b <= a) return '0;
    if (skip_until_cfg > skip_from_cfg) begin
      lo = (a > skip_from_cfg) ? a : skip_from_cfg;
      hi = (b < skip_until_cfg) ? b : skip_until_cfg;
      if (hi > lo) cut = hi - lo;
    end
    return FIELD_W'(b - a - cut);
  endfunction

  function automatic void expand_byte(logic [7:0] b);
    longint unsigned cnt, run_end;
    logic done;
    lrle_res_t r;
    if (body_done) return;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      cnt = longint'(count_acc) * 10 + longint'(b - CH_ZERO);
      if (cnt > COUNT_MAX) cnt = COUNT_MAX;
      count_acc   = COUNT_BITS'(cnt);
      digits_seen = 1'b1;
      return;
    end
    cnt = digits_seen ? longint'(count_acc) : 1;
    count_acc   = '0;
    digits_seen = 1'b0;
    if (b == CH_B || b == CH_O) begin
      run_end = longint'(col_pos) + cnt;
      if (run_end > FIELD_MAX) run_end = FIELD_MAX;
      r = '{pixel_value: (b == CH_B), run_length: visible_cells(col_pos, run_end),
            ends_row: 1'b0, row_repeat: 16'd1, pattern_done: 1'b0, last: 1'b1};
      runs_due.push_back(r);
      col_pos = FIELD_W'(run_end);
    end else if (b == CH_DOLLAR || b == CH_BANG) begin
      done = (b == CH_BANG);
      if (done) body_done = 1'b1;
      if (cnt == 0) begin
        // zero count: '$' does nothing, '!' still reports the end
        if (done) begin
          r = '{pixel_value: 1'b1, run_length: '0, ends_row: 1'b0, row_repeat: '0,
                pattern_done: 1'b1, last: 1'b1};
          runs_due.push_back(r);
        end
      end else begin
        r = '{pixel_value: 1'b1, run_length: visible_cells(col_pos, row_width_cfg),
              ends_row: 1'b1, row_repeat: 16'd1, pattern_done: done, last: (cnt == 1)};
        runs_due.push_back(r);
        if (cnt > 1) begin
          r = '{pixel_value: 1'b1, run_length: visible_cells(0, row_width_cfg),
                ends_row: 1'b1, row_repeat: FIELD_W'((cnt - 1 > FIELD_MAX) ? FIELD_MAX : cnt - 1),
                pattern_done: done, last: 1'b1};
          runs_due.push_back(r);
        end
        col_pos = '0;
      end
    end
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial forever begin
    @(hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  lrle_res_t seen, want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{pixel_value: out_ch.pixel_value, run_length: out_ch.run_length,
               ends_row: out_ch.ends_row, row_repeat: out_ch.row_repeat,
               pattern_done: out_ch.pattern_done, last: out_ch.last};
      if (runs_due.size() == 0) begin
        flag_mismatch("item with nothing expected, run_length", seen.run_length, 0);
      end else begin
        want = runs_due.pop_front();
        if (seen.pixel_value !== want.pixel_value)
          flag_mismatch("pixel_value", seen.pixel_value, want.pixel_value);
        if (seen.run_length !== want.run_length)
          flag_mismatch("run_length", seen.run_length, want.run_length);
        if (seen.ends_row !== want.ends_row)
          flag_mismatch("ends_row", seen.ends_row, want.ends_row);
        if (seen.row_repeat !== want.row_repeat)
          flag_mismatch("row_repeat", seen.row_repeat, want.row_repeat);
        if (seen.pattern_done !== want.pattern_done)
          flag_mismatch("pattern_done", seen.pattern_done, want.pattern_done);
        if (seen.last !== want.last)
          flag_mismatch("last", seen.last, want.last);
      end
      results_seen++;
    end
  end

  int unsigned cycle_count = 0;
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles", cycle_count);
    $display("life_rle_run_expander_unit verification failed");
    $finish;
  end

  // Leaves valid high after the accepting edge; a drain, or an idle cycle in the next call, lowers it
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.body_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expand_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    // digits leave no result behind; give them time to land
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_columns(logic [FIELD_W-1:0] rw, logic [FIELD_W-1:0] sf,
                             logic [FIELD_W-1:0] su);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ROW_WIDTH;
    cfg_data <= rw;
    @(posedge clk);
    cfg_idx  <= REG_SKIP_FROM;
    cfg_data <= sf;
    @(posedge clk);
    cfg_idx  <= REG_SKIP_UNTIL;
    cfg_data <= su;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_width_cfg  = rw;
    skip_from_cfg  = sf;
    skip_until_cfg = su;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] nb;
    nb = 8'($urandom_range(0, 255));
    // keep the pattern open; end markers are only sent by the final pattern-end test
    if (nb == CH_BANG) nb = CH_O;
    return nb;
  endfunction

  // Mostly well-formed tokens, with noise and broken counts mixed in
  task automatic send_token();
    int unsigned pick, ndig;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_byte(noise_byte());
    end else if (pick < 8) begin
      send_byte(8'h0A);
    end else begin
      pick = $urandom_range(0, 99);
      ndig = (pick < 35) ? 0 : (pick < 75) ? 1 : (pick < 90) ? 2 : $urandom_range(3, 5);
      repeat (ndig) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      if (ndig != 0 && $urandom_range(0, 99) < 5) send_byte(noise_byte());
      pick = $urandom_range(0, 99);
      send_byte((pick < 40) ? CH_B : (pick < 75) ? CH_O : CH_DOLLAR);
    end
  endtask

  task automatic test_reset_config();
    send_text("3o2$b");
  endtask

  task automatic test_directed_runs();
    drain_results();
    set_columns(16'd10, 16'd3, 16'd6);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("bo0b0$4o$");
    // a count cut short by another byte is dropped
    send_text("7\nb");
    // count saturation, column saturation, fill from past the width
    send_text("99999b5o$");
    send_text("3$12b$");
  endtask

  task automatic test_random_runs(logic [FIELD_W-1:0] rw, logic [FIELD_W-1:0] sf,
                                  logic [FIELD_W-1:0] su);
    int unsigned sent;
    drain_results();
    set_columns(rw, sf, su);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      send_token();
      sent += 2;
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  task automatic test_output_stall();
    drain_results();
    set_columns(16'd50, 16'd20, 16'd30);
    -> hold_go;
    repeat (60) send_token();
    drain_results();
  endtask

  task automatic test_pattern_end();
    int unsigned style;
    style = $urandom_range(0, 2);
    drain_results();
    set_columns(16'd12, 16'd4, 16'd9);
    send_text("5b");
    if (style == 0) begin
      send_text("0!");
    end else if (style == 1) begin
      send_byte(CH_BANG);
    end else begin
      send_byte(CH_ZERO + 8'($urandom_range(2, 9)));
      send_byte(CH_BANG);
    end
    // everything after the end marker is ignored
    send_text("3b$7!o\n");
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.body_byte = '0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_ROW_WIDTH;
    cfg_data        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    reset_model();

    test_reset_config();
    test_directed_runs();

    send_idle_pct = 17;
    recv_idle_pct = 69;
    test_random_runs(16'd1, 16'd0, 16'd0);
    test_random_runs(16'd37, 16'd10, 16'd20);

    send_idle_pct = 69;
    recv_idle_pct = 17;
    test_random_runs(16'd65535, 16'd0, 16'd65535);
    test_random_runs(16'd64, 16'd65535, 16'd0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_runs(16'($urandom_range(1, 200)), 16'($urandom_range(0, 200)),
                     16'($urandom_range(0, 200)));
    test_random_runs(16'd65535, 16'd60000, 16'd65535);

    test_output_stall();
    test_pattern_end();
    drain_results();

    if (runs_due.size() != 0) flag_mismatch("results never delivered", runs_due.size(), 0);
    if (mismatches == 0) begin
      $display("life_rle_run_expander_unit verification clean");
    end else begin
      $display("life_rle_run_expander_unit verification failed");
    end
    $finish;
  end

endmodule
